FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clock, idle during reset.
`define ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// Next-cycle implication, sampled on clock, idle during reset.
`define ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)
`endif

`endif

FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes, status codes and UTF-8 helpers for the unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last;
      logic [2:0] status;
   } rsp_type;

   localparam int MaxResults = 4;

   // Up to four results caused by one input transaction; slot 0 goes out first.
   typedef struct packed {
      rsp_type [MaxResults-1:0] items;
      logic [2:0]               count;
   } burst_type;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_UNTERM_STR  = 3'd1;
   localparam logic [2:0] ST_UNTERM_ESC  = 3'd2;
   localparam logic [2:0] ST_BAD_ESC     = 3'd3;
   localparam logic [2:0] ST_BAD_HEX     = 3'd4;
   localparam logic [2:0] ST_INCOMPLETE  = 3'd5;
   localparam logic [2:0] ST_MISSING_LOW = 3'd6;
   localparam logic [2:0] ST_BAD_LOW     = 3'd7;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CTL_BS    = 8'h08;
   localparam logic [7:0] CTL_FF    = 8'h0C;
   localparam logic [7:0] CTL_LF    = 8'h0A;
   localparam logic [7:0] CTL_CR    = 8'h0D;
   localparam logic [7:0] CTL_TAB   = 8'h09;

   localparam logic [15:0] SURR_HI_MIN = 16'hD800;
   localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
   localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
   localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;
   localparam logic [20:0] LIM_ONE     = 21'h80;
   localparam logic [20:0] LIM_TWO     = 21'h800;
   localparam logic [20:0] LIM_THREE   = 21'h10000;
   localparam logic [7:0]  CONT_MARK   = 8'h80;
   localparam logic [7:0]  LEAD_TWO    = 8'hC0;
   localparam logic [7:0]  LEAD_THREE  = 8'hE0;
   localparam logic [7:0]  LEAD_FOUR   = 8'hF0;

   // {ok, value}: ok is low for a character that is no hex digit.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         r = {1'b1, c[3:0] + 4'd9};
      else r = 5'd0;
      return r;
   endfunction

   function automatic rsp_type byte_rsp(input logic [7:0] b);
      rsp_type r;
      r.out_byte = b;
      r.has_byte = 1'b1;
      r.last     = 1'b0;
      r.status   = ST_OK;
      return r;
   endfunction

   function automatic burst_type single_burst(input logic [7:0] b);
      burst_type r;
      r          = '0;
      r.items[0] = byte_rsp(b);
      r.count    = 3'd1;
      return r;
   endfunction

   function automatic burst_type close_burst(input logic [2:0] st);
      burst_type r;
      r                 = '0;
      r.items[0].last   = 1'b1;
      r.items[0].status = st;
      r.count           = 3'd1;
      return r;
   endfunction

   function automatic burst_type utf8_burst(input logic [20:0] cp);
      burst_type r;
      r = '0;
      if (cp < LIM_ONE) begin
         r.items[0] = byte_rsp(cp[7:0]);
         r.count    = 3'd1;
      end else if (cp < LIM_TWO) begin
         r.items[0] = byte_rsp(LEAD_TWO | {3'b000, cp[10:6]});
         r.items[1] = byte_rsp(CONT_MARK | {2'b00, cp[5:0]});
         r.count    = 3'd2;
      end else if (cp < LIM_THREE) begin
         r.items[0] = byte_rsp(LEAD_THREE | {4'b0000, cp[15:12]});
         r.items[1] = byte_rsp(CONT_MARK | {2'b00, cp[11:6]});
         r.items[2] = byte_rsp(CONT_MARK | {2'b00, cp[5:0]});
         r.count    = 3'd3;
      end else begin
         r.items[0] = byte_rsp(LEAD_FOUR | {5'b00000, cp[20:18]});
         r.items[1] = byte_rsp(CONT_MARK | {2'b00, cp[17:12]});
         r.items[2] = byte_rsp(CONT_MARK | {2'b00, cp[11:6]});
         r.items[3] = byte_rsp(CONT_MARK | {2'b00, cp[5:0]});
         r.count    = 3'd4;
      end
      return r;
   endfunction

endpackage

FILE: rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape-decoding state machine: one byte per step, yields a result burst.
// ----------------------------------------------------------------------------
module jsu_decode
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      step,
   input  req_type   req,
   output burst_type burst
);

   typedef enum logic [2:0] {
      MODE_PLAIN, MODE_ESC, MODE_HEX_HI, MODE_WANT_BS, MODE_WANT_U, MODE_HEX_LO
   } mode_type;

   mode_type    mode_ff,  mode_in;
   logic [1:0]  digit_ff, digit_in;
   logic [15:0] code_ff,  code_in;
   logic [9:0]  high_ff,  high_in;
   logic        bad_ff,   bad_in;

   logic [4:0]  nib;
   logic [15:0] acc;
   logic        bad;
   logic        clear;

   always_comb begin
      nib      = hex_nibble(req.data_byte);
      acc      = {code_ff[11:0], nib[3:0]};
      bad      = bad_ff | ~nib[4];
      mode_in  = mode_ff;
      digit_in = digit_ff;
      code_in  = code_ff;
      high_in  = high_ff;
      bad_in   = bad_ff;
      clear    = 1'b0;
      burst    = '0;

      case (mode_ff)
         MODE_PLAIN: begin
            if (req.end_of_data) begin
               burst = close_burst(ST_UNTERM_STR);
               clear = 1'b1;
            end else if (req.data_byte == CH_QUOTE) begin
               burst = close_burst(ST_OK);
               clear = 1'b1;
            end else if (req.data_byte == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               burst = single_burst(req.data_byte);
            end
         end
         MODE_ESC: begin
            if (req.end_of_data) begin
               burst = close_burst(ST_UNTERM_ESC);
               clear = 1'b1;
            end else begin
               mode_in = MODE_PLAIN;
               case (req.data_byte)
                  CH_QUOTE:  burst = single_burst(CH_QUOTE);
                  CH_BSLASH: burst = single_burst(CH_BSLASH);
                  CH_SLASH:  burst = single_burst(CH_SLASH);
                  CH_B:      burst = single_burst(CTL_BS);
                  CH_F:      burst = single_burst(CTL_FF);
                  CH_N:      burst = single_burst(CTL_LF);
                  CH_R:      burst = single_burst(CTL_CR);
                  CH_T:      burst = single_burst(CTL_TAB);
                  CH_U: begin
                     mode_in  = MODE_HEX_HI;
                     digit_in = 2'd0;
                     code_in  = 16'd0;
                     bad_in   = 1'b0;
                  end
                  default: begin
                     burst = close_burst(ST_BAD_ESC);
                     clear = 1'b1;
                  end
               endcase
            end
         end
         MODE_HEX_HI: begin
            if (req.end_of_data) begin
               burst = close_burst(ST_INCOMPLETE);
               clear = 1'b1;
            end else begin
               code_in  = acc;
               bad_in   = bad;
               digit_in = digit_ff + 2'd1;
               if (digit_ff == 2'd3) begin
                  if (bad) begin
                     burst = close_burst(ST_BAD_HEX);
                     clear = 1'b1;
                  end else if (acc inside {[SURR_HI_MIN:SURR_HI_MAX]}) begin
                     high_in = acc[9:0];
                     code_in = 16'd0;
                     mode_in = MODE_WANT_BS;
                  end else begin
                     burst = utf8_burst({5'd0, acc});
                     clear = 1'b1;
                  end
               end
            end
         end
         MODE_WANT_BS: begin
            if (req.end_of_data || req.data_byte != CH_BSLASH) begin
               burst = close_burst(ST_MISSING_LOW);
               clear = 1'b1;
            end else begin
               mode_in = MODE_WANT_U;
            end
         end
         MODE_WANT_U: begin
            if (req.end_of_data || req.data_byte != CH_U) begin
               burst = close_burst(ST_MISSING_LOW);
               clear = 1'b1;
            end else begin
               mode_in  = MODE_HEX_LO;
               digit_in = 2'd0;
               code_in  = 16'd0;
               bad_in   = 1'b0;
            end
         end
         MODE_HEX_LO: begin
            if (req.end_of_data) begin
               burst = close_burst(ST_MISSING_LOW);
               clear = 1'b1;
            end else begin
               code_in  = acc;
               bad_in   = bad;
               digit_in = digit_ff + 2'd1;
               if (digit_ff == 2'd3) begin
                  clear = 1'b1;
                  if (bad) begin
                     burst = close_burst(ST_BAD_HEX);
                  end else if (!(acc inside {[SURR_LO_MIN:SURR_LO_MAX]})) begin
                     burst = close_burst(ST_BAD_LOW);
                  end else begin
                     burst = utf8_burst(SUPP_BASE + {1'b0, high_ff, acc[9:0]});
                  end
               end
            end
         end
         default: begin
            clear = 1'b1;
         end
      endcase

      // Drop back to plain text after a close, a finished code point or an unknown mode.
      if (clear) begin
         mode_in  = MODE_PLAIN;
         digit_in = 2'd0;
         code_in  = 16'd0;
         high_in  = 10'd0;
         bad_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         digit_ff <= 2'd0;
         code_ff  <= 16'd0;
         high_ff  <= 10'd0;
         bad_ff   <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         code_ff  <= code_in;
         high_ff  <= high_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

FILE: rtl/json_string_unescape.sv
// Path: a taken input transaction goes into the input register; its result
// is loaded into the result register once that register is free.
// Throughput: one input byte per cycle while the result register is free; the k
// UTF-8 bytes of one escape hold it and go out one per cycle while rsp_ready is high.
// Reset: synchronous, active high; clears both valid flags and the decoder.
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming unescaper for a JSON string body, \u escapes decoded to UTF-8.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_unescape
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Input register: parts the request side from the result side, so a
   // transaction is taken while an earlier result still waits.
   req_type in_ff, in_in;
   logic    in_vld_ff, in_vld_in;

   // Result register: a burst of up to four results, shifted out from slot 0.
   rsp_type [MaxResults-1:0] res_ff, res_in;
   logic [2:0]               cnt_ff, cnt_in;

   burst_type burst;
   logic      pop;
   logic      out_free;
   logic      step;

   // Advance the decoder when the result register is empty or empties this cycle.
   assign pop      = (cnt_ff != 3'd0) && rsp_ready;
   assign out_free = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_ready);
   assign step     = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || step;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_data  = res_ff[0];

   jsu_decode u_decode (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_ff),
      .burst (burst)
   );

   always_comb begin
      in_in     = in_ff;
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_in     = req_data;
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (step) begin
         // Load the whole burst; a transaction that yields nothing leaves it empty.
         res_in = burst.items;
         cnt_in = burst.count;
      end else if (pop) begin
         // Shift the next byte of a multi-byte run into the output slot.
         for (int i = 0; i < MaxResults - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
         res_in[MaxResults-1] = '0;
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cnt_ff    <= 3'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         cnt_ff    <= cnt_in;
      end
      in_ff  <= in_in;
      res_ff <= res_in;
   end

   // A closing transaction never shares the result register with bytes.
   `ASSERT_IMPLIES(a_close_alone, rsp_valid && rsp_data.last, cnt_ff == 3'd1)
   // The register never holds more than one full UTF-8 sequence.
   `ASSERT_IMPLIES(a_cnt_range, 1'b1, cnt_ff <= 3'd4)
   // Every decoder step that yields results presents them next cycle.
   `ASSERT_NEXT(a_step_shows, step && (burst.count != 3'd0), rsp_valid)
   // Byte results carry no status and do not close the string.
   `ASSERT_IMPLIES(a_byte_clean, rsp_valid && rsp_data.has_byte,
                   !rsp_data.last && (rsp_data.status == ST_OK))

endmodule
